[rtl/rau_pkg.sv]
// shared widths and types for the rational arithmetic unit
// used by rau_div and rational_arithmetic_unit
package rau_pkg;

    localparam int OW   = 16;               // operand width
    localparam int DW   = 2 * OW + 2;       // internal datapath width
    localparam int OUTW = 33;               // result field width
    localparam int CW   = $clog2(DW + 1);   // divider step counter width

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } t_func;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] dividend;
        logic signed [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] quot;
        logic signed [DW-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/rau_div.sv]
// bit-serial signed divider with truncating quotient and remainder
// depends on rau_pkg
module rau_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rau_pkg::t_div_req i_req,
    output rau_pkg::t_div_rsp o_rsp
);
    import rau_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic          r_qneg;
    logic          r_rneg;
    logic [DW:0]   trial;
    logic [DW-1:0] abs_n;
    logic [DW-1:0] abs_d;

    assign abs_n = i_req.dividend[DW-1] ? DW'(-i_req.dividend) : DW'(i_req.dividend);
    assign abs_d = i_req.divisor[DW-1]  ? DW'(-i_req.divisor)  : DW'(i_req.divisor);
    assign trial = {r_rem, r_quo[DW-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_rem  <= '0;
                r_quo  <= abs_n;
                r_den  <= abs_d;
                r_qneg <= i_req.dividend[DW-1] ^ i_req.divisor[DW-1];
                r_rneg <= i_req.dividend[DW-1];
            end else if (r_busy) begin
                if (!trial[DW]) begin
                    r_rem <= trial[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? -$signed(r_quo) : $signed(r_quo);
    assign o_rsp.rem  = r_rneg ? -$signed(r_rem) : $signed(r_rem);

endmodule

[rtl/rational_arithmetic_unit.sv]
// top level: sequencer, shared multiplier, shared divider and operand registers
// depends on rau_pkg and rau_div
//
// One item is taken when start is high and busy is low; busy then stays high
// until the result shows on o_num_out/o_den_out with o_valid high for a single
// cycle, which the receiver must take as it comes. Every division goes through
// one bit-serial divider of 34 steps. An item runs one division for each Euclid
// remainder step of the common-denominator search (add and subtract only) and
// of the final reduction, plus three divisions for the common denominator and
// two for the reduction; the reduction is skipped when either part is zero.
module rational_arithmetic_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_func,
    input  logic signed [15:0]     i_num_a,
    input  logic signed [15:0]     i_den_a,
    input  logic signed [15:0]     i_num_b,
    input  logic signed [15:0]     i_den_b,
    output logic                   o_valid,
    output logic signed [32:0]     o_num_out,
    output logic signed [32:0]     o_den_out
);
    import rau_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_M1, S_M2, S_DD,
        S_GSETUP, S_GISSUE, S_GWAIT,
        S_LISSUE, S_LWAIT, S_QAISSUE, S_QAWAIT, S_MA,
        S_QBISSUE, S_QBWAIT, S_MB, S_COMB,
        S_RCHECK, S_RNISSUE, S_RNWAIT, S_RDISSUE, S_RDWAIT, S_DONE
    } t_state;

    t_state               r_state;
    t_func                r_func;
    logic                 r_gret;     // 0: common denominator, 1: reduction
    logic signed [DW-1:0] r_na, r_da, r_nb, r_db;
    logic signed [DW-1:0] r_ga, r_gb, r_g;
    logic signed [DW-1:0] r_p, r_l, r_q, r_ta, r_tb;
    logic signed [DW-1:0] r_rn, r_rd;

    logic signed [OW:0]   mul_x, mul_y;
    logic signed [DW-1:0] prod;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    // shared multiplier operand select
    always_comb begin
        mul_x = r_na[OW:0];
        mul_y = r_nb[OW:0];
        unique case (r_state)
            S_M1: begin
                mul_x = r_na[OW:0];
                mul_y = (r_func == FN_MUL) ? r_nb[OW:0] : r_db[OW:0];
            end
            S_M2: begin
                mul_x = r_da[OW:0];
                mul_y = (r_func == FN_MUL) ? r_db[OW:0] : r_nb[OW:0];
            end
            S_DD: begin
                mul_x = r_da[OW:0];
                mul_y = r_db[OW:0];
            end
            S_MA: begin
                mul_x = r_q[OW:0];
                mul_y = r_na[OW:0];
            end
            S_MB: begin
                mul_x = r_q[OW:0];
                mul_y = r_nb[OW:0];
            end
            default: begin
                mul_x = r_na[OW:0];
                mul_y = r_nb[OW:0];
            end
        endcase
    end

    // full-width signed product of the two 17-bit operands
    assign prod = DW'(mul_x) * DW'(mul_y);

    // shared divider operand select
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_ga;
        div_req.divisor  = r_gb;
        unique case (r_state)
            S_GISSUE: begin
                div_req.start = 1'b1;
            end
            S_LISSUE: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_p;
                div_req.divisor  = r_g;
            end
            S_QAISSUE: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_l;
                div_req.divisor  = r_da;
            end
            S_QBISSUE: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_l;
                div_req.divisor  = r_db;
            end
            S_RNISSUE: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_rn;
                div_req.divisor  = r_g;
            end
            S_RDISSUE: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_rd;
                div_req.divisor  = r_g;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            busy    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        busy    <= 1'b1;
                        r_func  <= t_func'(i_func);
                        r_na    <= DW'(i_num_a);
                        r_da    <= DW'(i_den_a);
                        r_nb    <= DW'(i_num_b);
                        r_db    <= DW'(i_den_b);
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_func == FN_MUL || r_func == FN_DIV) begin
                        r_state <= S_M1;
                    end else if (r_da == '0 || r_db == '0) begin
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_state <= S_RCHECK;
                    end else begin
                        r_state <= S_DD;
                    end
                end
                S_M1: begin
                    r_rn    <= prod;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_rd    <= prod;
                    r_state <= S_RCHECK;
                end
                S_DD: begin
                    r_p     <= prod;
                    r_ga    <= r_da;
                    r_gb    <= r_db;
                    r_gret  <= 1'b0;
                    r_state <= S_GSETUP;
                end
                S_GSETUP: begin
                    if (r_gb > r_ga) begin
                        r_ga <= r_gb;
                        r_gb <= r_ga;
                    end
                    r_state <= S_GISSUE;
                end
                S_GISSUE: r_state <= S_GWAIT;
                S_GWAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.rem == '0) begin
                            r_g     <= r_gb;
                            r_state <= r_gret ? S_RNISSUE : S_LISSUE;
                        end else begin
                            r_ga    <= r_gb;
                            r_gb    <= div_rsp.rem;
                            r_state <= S_GISSUE;
                        end
                    end
                end
                S_LISSUE: r_state <= S_LWAIT;
                S_LWAIT: begin
                    if (div_rsp.done) begin
                        r_l     <= div_rsp.quot;
                        r_state <= S_QAISSUE;
                    end
                end
                S_QAISSUE: r_state <= S_QAWAIT;
                S_QAWAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quot;
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    r_ta    <= prod;
                    r_state <= S_QBISSUE;
                end
                S_QBISSUE: r_state <= S_QBWAIT;
                S_QBWAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quot;
                        r_state <= S_MB;
                    end
                end
                S_MB: begin
                    r_tb    <= prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    // subtract flips a negative common denominator
                    if (r_func == FN_SUB && r_l[DW-1]) begin
                        r_rn <= r_tb - r_ta;
                        r_rd <= -r_l;
                    end else begin
                        r_rn <= (r_func == FN_SUB) ? r_ta - r_tb : r_ta + r_tb;
                        r_rd <= r_l;
                    end
                    r_state <= S_RCHECK;
                end
                S_RCHECK: begin
                    if (r_rn == '0 || r_rd == '0) begin
                        r_rn    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_ga    <= r_rd;
                        r_gb    <= r_rn;
                        r_gret  <= 1'b1;
                        r_state <= S_GSETUP;
                    end
                end
                S_RNISSUE: r_state <= S_RNWAIT;
                S_RNWAIT: begin
                    if (div_rsp.done) begin
                        r_rn    <= div_rsp.quot;
                        r_state <= S_RDISSUE;
                    end
                end
                S_RDISSUE: r_state <= S_RDWAIT;
                S_RDWAIT: begin
                    if (div_rsp.done) begin
                        r_rd    <= div_rsp.quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_valid   <= 1'b1;
                    o_num_out <= r_rn[OUTW-1:0];
                    o_den_out <= r_rd[OUTW-1:0];
                    busy      <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/rau_checker.sv]
// port-level checks on the rational arithmetic unit
// bound to rational_arithmetic_unit; no package use
module rau_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item taken but busy not raised");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
